FILE: hw/rtl/tspc_pkg.sv
`default_nettype none

package tspc_pkg;

    localparam int TSPC_TICK_MS      = 100;
    localparam int TSPC_TRAVEL_MAX   = 250;
    localparam int TSPC_TRAVEL_RESET = 10;

    localparam int TSPC_POS_W = 17;
    localparam int TSPC_PCT_W = 7;
    localparam logic [TSPC_POS_W-1:0] TSPC_FULL_Q10 = 17'd102400;
    localparam logic [7:0] TSPC_PCT_MAX = 8'd100;

    typedef enum logic [1:0] {
        MOVE_STILL = 2'd0,
        MOVE_UP    = 2'd1,
        MOVE_DOWN  = 2'd2
    } motion_t;

endpackage

`default_nettype wire

FILE: hw/rtl/timed_shutter_position_controller.sv
// Command item or tick while still: the item is registered and goes to ST_EXEC,
// which registers the result; the next input is taken only back in ST_IDLE.
// Tick while moving: ST_DIV runs before ST_EXEC registers the result; the step
// is re-derived each tick by a restoring divider, one quotient bit per cycle.
// A stalled result holds the block.
// aresetn (synchronous, active low): travel time 10 s, position unknown,
// relays off, no report pending, output channel empty.
`default_nettype none

module timed_shutter_position_controller #(
    parameter int TICK_MS = tspc_pkg::TSPC_TICK_MS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [7:0]                    cfg_travel_time_s,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [7:0]                    s_target_percent,
    input  wire logic                          s_link_ready,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_power_relay,
    output logic                               m_direction_relay,
    output tspc_pkg::motion_t                  m_motion,
    output logic                               m_report_valid,
    output logic [tspc_pkg::TSPC_PCT_W-1:0]    m_report_position
);
    import tspc_pkg::*;

    localparam int NUM    = 100 * TICK_MS * 1024;
    localparam int NUM_W  = $clog2(NUM + 1);
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int STEP_W = $clog2(NUM / 1000 + 1);
    localparam int DEN_W  = $clog2(TSPC_TRAVEL_MAX * 1000 + 1);
    localparam int REM_W  = DEN_W + 1;
    localparam logic [NUM_W-1:0] NUM_VEC = NUM_W'(NUM);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] travel_reg, travel_next;

    logic [TSPC_POS_W-1:0] pos_reg, pos_next;
    logic [TSPC_PCT_W-1:0] goal_reg, goal_next;
    motion_t               move_reg, move_next;
    logic known_reg, known_next;
    logic pend_reg, pend_next;
    logic dir_reg, dir_next;
    logic pwr_reg, pwr_next;

    logic       func_reg, func_next;
    logic [7:0] tgt_reg, tgt_next;
    logic       link_reg, link_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] quo_reg, quo_next;

    logic                  mv_reg, mv_next;
    logic                  o_pwr_reg, o_pwr_next;
    logic                  o_dir_reg, o_dir_next;
    motion_t               o_mot_reg, o_mot_next;
    logic                  o_rv_reg, o_rv_next;
    logic [TSPC_PCT_W-1:0] o_rp_reg, o_rp_next;

    logic [DEN_W-1:0]      den;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      rem_sub;
    logic [TSPC_POS_W-1:0] step;
    logic [TSPC_POS_W:0]   pos_sum;
    logic [TSPC_POS_W-1:0] tq;
    logic [TSPC_POS_W-1:0] gq;
    logic                  out_free;

    assign den      = DEN_W'(travel_reg * 18'd1000);
    assign rem_sh   = {rem_reg, NUM_VEC[cnt_reg]};
    assign rem_sub  = rem_sh - {1'b0, den};
    assign step     = (quo_reg == '0) ? TSPC_POS_W'(1) : TSPC_POS_W'(quo_reg);
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step};
    assign tq       = {tgt_reg[TSPC_PCT_W-1:0], 10'd0};
    assign gq       = {goal_reg, 10'd0};
    assign out_free = !mv_reg || m_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    assign m_valid           = mv_reg;
    assign m_power_relay     = o_pwr_reg;
    assign m_direction_relay = o_dir_reg;
    assign m_motion          = o_mot_reg;
    assign m_report_valid    = o_rv_reg;
    assign m_report_position = o_rp_reg;

    always_comb begin
        motion_t m;
        logic    apply;

        state_next  = state_reg;
        travel_next = travel_reg;
        pos_next    = pos_reg;
        goal_next   = goal_reg;
        move_next   = move_reg;
        known_next  = known_reg;
        pend_next   = pend_reg;
        dir_next    = dir_reg;
        pwr_next    = pwr_reg;
        func_next   = func_reg;
        tgt_next    = tgt_reg;
        link_next   = link_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        mv_next     = mv_reg;
        o_pwr_next  = o_pwr_reg;
        o_dir_next  = o_dir_reg;
        o_mot_next  = o_mot_reg;
        o_rv_next   = o_rv_reg;
        o_rp_next   = o_rp_reg;
        m           = MOVE_STILL;
        apply       = 1'b0;

        if (cfg_valid && (cfg_travel_time_s inside {[1:TSPC_TRAVEL_MAX]})) begin
            travel_next = cfg_travel_time_s;
        end

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next = s_func;
                    tgt_next  = s_target_percent;
                    link_next = s_link_ready;
                    cnt_next  = CNT_LAST;
                    rem_next  = '0;
                    quo_next  = '0;
                    if (s_func && move_reg != MOVE_STILL) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_DIV: begin
                // remainder stays below den, so it fits in DEN_W bits
                if (rem_sh >= {1'b0, den}) begin
                    rem_next = rem_sub[DEN_W-1:0];
                    quo_next = {quo_reg[STEP_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[DEN_W-1:0];
                    quo_next = {quo_reg[STEP_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    state_next = ST_EXEC;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    o_rv_next = 1'b0;
                    o_rp_next = '0;
                    if (!func_reg) begin
                        if (tgt_reg > TSPC_PCT_MAX) begin
                            pend_next = 1'b1;
                        end else begin
                            apply     = 1'b1;
                            goal_next = tgt_reg[TSPC_PCT_W-1:0];
                            if (!known_reg) begin
                                m          = (tgt_reg == TSPC_PCT_MAX) ? MOVE_DOWN : MOVE_UP;
                                pos_next   = (tgt_reg == TSPC_PCT_MAX) ? '0 : TSPC_FULL_Q10;
                                known_next = 1'b1;
                            end else if (tq == pos_reg) begin
                                m = MOVE_STILL;
                            end else if (tq > pos_reg) begin
                                m = MOVE_DOWN;
                            end else begin
                                m = MOVE_UP;
                            end
                        end
                    end else begin
                        // report carries the position before this tick's advance
                        if (pend_reg && link_reg) begin
                            o_rv_next = 1'b1;
                            o_rp_next = pos_reg[TSPC_POS_W-1:10];
                            pend_next = 1'b0;
                        end
                        if (move_reg == MOVE_STILL) begin
                            dir_next = 1'b0;
                        end else if (move_reg == MOVE_UP) begin
                            pos_next = (pos_reg > step) ? pos_reg - step : '0;
                            if (pos_next <= gq) begin
                                apply = 1'b1;
                            end
                        end else begin
                            pos_next = (pos_sum > {1'b0, TSPC_FULL_Q10}) ? TSPC_FULL_Q10
                                                                         : pos_sum[TSPC_POS_W-1:0];
                            if (pos_next >= gq) begin
                                apply = 1'b1;
                            end
                        end
                    end

                    if (apply) begin
                        move_next = m;
                        if (m == MOVE_STILL) begin
                            pwr_next  = 1'b0;
                            pend_next = 1'b1;
                        end else begin
                            dir_next = (m == MOVE_UP);
                            pwr_next = 1'b1;
                        end
                    end

                    o_pwr_next = pwr_next;
                    o_dir_next = dir_next;
                    o_mot_next = move_next;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            travel_reg <= 8'(TSPC_TRAVEL_RESET);
            pos_reg    <= '0;
            goal_reg   <= '0;
            move_reg   <= MOVE_STILL;
            known_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            dir_reg    <= 1'b0;
            pwr_reg    <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            travel_reg <= travel_next;
            pos_reg    <= pos_next;
            goal_reg   <= goal_next;
            move_reg   <= move_next;
            known_reg  <= known_next;
            pend_reg   <= pend_next;
            dir_reg    <= dir_next;
            pwr_reg    <= pwr_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        tgt_reg   <= tgt_next;
        link_reg  <= link_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        o_pwr_reg <= o_pwr_next;
        o_dir_reg <= o_dir_next;
        o_mot_reg <= o_mot_next;
        o_rv_reg  <= o_rv_next;
        o_rp_reg  <= o_rp_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tspc_checker.sv
`default_nettype none

module tspc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_power_relay,
    input wire logic                          m_direction_relay,
    input wire tspc_pkg::motion_t             m_motion,
    input wire logic                          m_report_valid,
    input wire logic [tspc_pkg::TSPC_PCT_W-1:0] m_report_position
);
    import tspc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_relay)
            && $stable(m_direction_relay) && $stable(m_motion)
            && $stable(m_report_valid) && $stable(m_report_position))
        else $error("result changed while stalled");

    // power follows motion, direction matches the moving sense
    a_relays: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_power_relay == (m_motion != MOVE_STILL))
            && (m_motion != MOVE_UP || m_direction_relay)
            && (m_motion != MOVE_DOWN || !m_direction_relay))
        else $error("relay levels disagree with motion");

    a_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_report_valid || m_report_position == '0)
            && m_report_position <= TSPC_PCT_W'(100))
        else $error("bad report position");

    // one item in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

endmodule

bind timed_shutter_position_controller tspc_checker u_tspc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_power_relay     (m_power_relay),
    .m_direction_relay (m_direction_relay),
    .m_motion          (m_motion),
    .m_report_valid    (m_report_valid),
    .m_report_position (m_report_position)
);

`default_nettype wire
